>>> sv/assert_macros.svh
// Assertion macros shared by the ASCII85 encoder RTL.
// No dependencies; each user module has clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, checking disabled while reset is asserted.
`define A85_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define A85_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

>>> sv/a85lw_pkg.sv
// Package for the line-wrapped ASCII85 encoder: constants, job type, back-end states.
// No dependencies.
`timescale 1ns / 1ps

package a85lw_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] MAX_COLUMN_RESET = 8'd72;

  // floor(x / 85) == (x * RECIP_85) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_85    = 32'hC0C0_C0C1;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned QUOT_W      = 64 - RECIP_SHIFT;

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned DIGIT_W    = 7;
  localparam logic [DIGIT_W-1:0] DIGIT_BASE = 7'd85;
  localparam logic [2:0]         TOP_DIGIT  = 3'(NUM_DIGITS - 1);
  localparam logic [2:0]         FULL_DIGITS = 3'(NUM_DIGITS);

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [7:0] CHAR_OFFSET = 8'd33;
  localparam logic [7:0] CHAR_Z      = 8'h7A;
  localparam logic [7:0] CHAR_NL     = 8'h0A;
  localparam logic [7:0] CHAR_TILDE  = 8'h7E;
  localparam logic [7:0] CHAR_GT     = 8'h3E;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    logic                                is_end;   // terminator follows
    logic                                is_zero;  // all-zero full group, emit 'z'
    logic [2:0]                          ndig;     // digits to emit, MSB first
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits;   // base-85 digits, [4] is MSB
  } a85_job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIGIT,
    BK_ZCHAR,
    BK_NL,
    BK_TILDE,
    BK_GT,
    BK_TERM
  } bk_state_t;

endpackage

>>> sv/ascii85_line_wrapped_encoder.sv
// Top level of the line-wrapped ASCII85 encoder: stream ports, width register.
// Depends on a85lw_pkg, a85lw_front, a85lw_queue, a85lw_back.
`timescale 1ns / 1ps

// ASCII85 encoder with line wrapping. Each input transaction carries either a
// data byte (in_tuser = 0) or an end-of-stream flush (in_tuser = 1). Bytes are
// gathered most significant first into 32-bit groups; a full group comes out
// as five base-85 digits (each plus 33), or as a single 'z' when the group is
// zero. After each group the line column is advanced and, once it reaches
// cfg max_column with bit 0 cleared, a newline follows. A flush emits the
// n+1 leading digits of a partial group of n bytes (zero padded), applies the
// same line check, then "~>" and a newline, and returns to the start state.
// out_tlast marks the final character caused by an input transaction; data
// bytes that do not close a group produce no output. Rate: the output runs at
// one character per cycle while out_tready allows, with a pass through BK_IDLE
// between jobs while the back end loads the next one from the queue. The front
// end converts a group on one shared 32x32 reciprocal multiplier (one base-85
// division per cycle) and keeps taking bytes of the next group meanwhile; it
// stalls only when a group closes or a flush arrives while the previous one is
// still converting or the job queue is full.
// max_column may only be written while the encoder is idle.
module ascii85_line_wrapped_encoder import a85lw_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] data_byte
  input  logic       in_tuser,    // [0] kind: 0 data byte, 1 end of stream
  // Output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_char
  output logic       out_tlast,
  // Line width register
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] max_column_r, max_column_nxt;

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  a85_job_t   push_job;
  a85_job_t   pop_job;

  // Line width register, write only.
  assign max_column_nxt = cfg_wr_en ? cfg_wr_data : max_column_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_column_r <= MAX_COLUMN_RESET;
    end else begin
      max_column_r <= max_column_nxt;
    end
  end

  // Front end: byte gathering and base-85 conversion.
  a85lw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_byte  (in_tdata),
    .q_full   (q_full),
    .push     (q_push),
    .push_job (push_job)
  );

  // Job queue decouples conversion from character output.
  a85lw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_job),
    .empty     (q_empty)
  );

  // Back end: character sequencing, line column, terminator.
  a85lw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_column (max_column_r),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

>>> sv/a85lw_queue.sv
// Small register FIFO of encoder jobs between front and back end.
// Depends on a85lw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module a85lw_queue import a85lw_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  a85_job_t push_data,
  output logic     full,
  input  logic     pop,
  output a85_job_t pop_data,
  output logic     empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  a85_job_t             mem_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `A85_ASSERT(a_queue_no_overflow, push |-> !full || pop, "job queue overflow")
  `A85_ASSERT(a_queue_no_underflow, pop |-> !empty, "job queue underflow")

endmodule

>>> sv/a85lw_front.sv
// Front end: gathers bytes into groups and converts each group to base-85 digits.
// Depends on a85lw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module a85lw_front import a85lw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_kind,
  input  logic [7:0] in_byte,
  input  logic     q_full,
  output logic     push,
  output a85_job_t push_job
);

  logic [23:0]              acc_r, acc_nxt;
  logic [1:0]               cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic [1:0]               step_r, step_nxt;
  logic [QUOT_W-1:0]        q_r, q_nxt;
  logic [DIGIT_W-1:0]       low_r, low_nxt;
  logic [2:0][DIGIT_W-1:0]  dig_r, dig_nxt;
  logic                     end_r, end_nxt;
  logic                     zero_r, zero_nxt;
  logic [2:0]               ndig_r, ndig_nxt;

  logic                     accept;
  logic                     start;
  logic [31:0]              grp_val;
  logic [31:0]              mul_in;
  logic [63:0]              mul_prod;
  logic [13:0]              q85;
  logic [DIGIT_W-1:0]       dig_cur;

  // A byte that does not close a group never needs the converter.
  assign in_ready = !busy_r || (in_kind == KIND_DATA && cnt_r != 2'd3);
  assign accept   = in_valid && in_ready;
  assign start    = accept && (in_kind == KIND_END || cnt_r == 2'd3);

  always_comb begin
    if (in_kind == KIND_DATA) begin
      grp_val = {acc_r, in_byte};
    end else begin
      case (cnt_r)
        2'd1:    grp_val = {acc_r[7:0], 24'd0};
        2'd2:    grp_val = {acc_r[15:0], 16'd0};
        2'd3:    grp_val = {acc_r, 8'd0};
        default: grp_val = '0;
      endcase
    end
  end

  // One divide-by-85 per cycle; the remainder only needs its low 7 bits.
  assign mul_in   = start ? grp_val : 32'(q_r);
  assign mul_prod = 64'(mul_in) * 64'(RECIP_85);
  assign q85      = 14'(q_r[DIGIT_W-1:0]) * 14'(DIGIT_BASE);
  assign dig_cur  = low_r - q85[DIGIT_W-1:0];

  assign push = busy_r && step_r == 2'd3 && !q_full;

  always_comb begin
    push_job.is_end    = end_r;
    push_job.is_zero   = zero_r;
    push_job.ndig      = ndig_r;
    push_job.digits[4] = q_r[DIGIT_W-1:0];
    push_job.digits[3] = dig_cur;
    push_job.digits[2] = dig_r[2];
    push_job.digits[1] = dig_r[1];
    push_job.digits[0] = dig_r[0];
  end

  always_comb begin
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    step_nxt = step_r;
    q_nxt    = q_r;
    low_nxt  = low_r;
    dig_nxt  = dig_r;
    end_nxt  = end_r;
    zero_nxt = zero_r;
    ndig_nxt = ndig_r;

    if (accept) begin
      if (in_kind == KIND_DATA) begin
        acc_nxt = {acc_r[15:0], in_byte};
        cnt_nxt = cnt_r + 2'd1;
      end else begin
        cnt_nxt = 2'd0;
      end
    end

    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
      q_nxt    = mul_prod[RECIP_SHIFT +: QUOT_W];
      low_nxt  = grp_val[DIGIT_W-1:0];
      end_nxt  = in_kind;
      zero_nxt = (in_kind == KIND_DATA) && (grp_val == '0);
      if (in_kind == KIND_DATA) begin
        ndig_nxt = FULL_DIGITS;
      end else begin
        ndig_nxt = (cnt_r == 2'd0) ? 3'd0 : {1'b0, cnt_r} + 3'd1;
      end
    end else if (busy_r && step_r != 2'd3) begin
      dig_nxt[step_r] = dig_cur;
      q_nxt           = mul_prod[RECIP_SHIFT +: QUOT_W];
      low_nxt         = q_r[DIGIT_W-1:0];
      step_nxt        = step_r + 2'd1;
    end else if (push) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    low_r  <= low_nxt;
    dig_r  <= dig_nxt;
    end_r  <= end_nxt;
    zero_r <= zero_nxt;
    ndig_r <= ndig_nxt;
  end

  `A85_ASSERT(a_front_push_frees, push |=> !busy_r, "converter still busy after push")
  `A85_ASSERT(a_front_steps_busy, busy_r && step_r != 2'd3 |=> busy_r && step_r != 2'd0,
    "converter dropped a group mid conversion")

endmodule

>>> sv/a85lw_back.sv
// Back end: emits one character per cycle from queued jobs while the output is not stalled, tracks the line column.
// Depends on a85lw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module a85lw_back import a85lw_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] max_column,
  input  logic       q_empty,
  input  a85_job_t   q_job,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  bk_state_t   state_r, state_nxt;
  a85_job_t    job_r, job_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [8:0]  col_r, col_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic        out_last_r, out_last_nxt;

  logic        emit_ok;
  logic        emit;
  logic        grp_done;
  logic [7:0]  char_v;
  logic        last_v;
  logic [2:0]  glen;
  logic [8:0]  col_new;
  logic [8:0]  width;

  assign emit_ok = !out_valid_r || out_ready;
  assign width   = {1'b0, max_column[7:1], 1'b0};
  assign glen    = (state_r == BK_ZCHAR) ? 3'd1 : job_r.ndig;
  assign col_new = col_r + 9'(glen);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    idx_nxt   = idx_r;
    col_nxt   = col_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    grp_done  = 1'b0;
    char_v    = CHAR_NL;
    last_v    = 1'b0;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          job_nxt = q_job;
          idx_nxt = 3'd0;
          if (q_job.is_end && q_job.ndig == 3'd0) begin
            state_nxt = BK_TILDE;
          end else if (q_job.is_zero) begin
            state_nxt = BK_ZCHAR;
          end else begin
            state_nxt = BK_DIGIT;
          end
        end
      end
      BK_DIGIT: begin
        if (emit_ok) begin
          emit    = 1'b1;
          char_v  = 8'(job_r.digits[TOP_DIGIT - idx_r]) + CHAR_OFFSET;
          idx_nxt = idx_r + 3'd1;
          if (idx_r == job_r.ndig - 3'd1) begin
            grp_done = 1'b1;
          end
        end
      end
      BK_ZCHAR: begin
        if (emit_ok) begin
          emit     = 1'b1;
          char_v   = CHAR_Z;
          grp_done = 1'b1;
        end
      end
      BK_NL: begin
        if (emit_ok) begin
          emit    = 1'b1;
          char_v  = CHAR_NL;
          col_nxt = '0;
          if (job_r.is_end) begin
            state_nxt = BK_TILDE;
          end else begin
            last_v    = 1'b1;
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_TILDE: begin
        if (emit_ok) begin
          emit      = 1'b1;
          char_v    = CHAR_TILDE;
          state_nxt = BK_GT;
        end
      end
      BK_GT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          char_v    = CHAR_GT;
          state_nxt = BK_TERM;
        end
      end
      BK_TERM: begin
        if (emit_ok) begin
          emit      = 1'b1;
          char_v    = CHAR_NL;
          last_v    = 1'b1;
          col_nxt   = '0;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // Line check after a group's last character.
    if (grp_done) begin
      col_nxt = col_new;
      if (col_new >= width) begin
        state_nxt = BK_NL;
      end else if (job_r.is_end) begin
        state_nxt = BK_TILDE;
      end else begin
        last_v    = 1'b1;
        state_nxt = BK_IDLE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = char_v;
      out_last_nxt  = last_v;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `A85_ASSERT(a_back_idle_no_char, $rose(out_valid_r) |-> $past(state_r) != BK_IDLE,
    "character emitted while back end idle")
  `A85_NEVER(a_back_char_known, out_valid_r && $isunknown({out_char_r, out_last_r}),
    "output character unknown while valid")

endmodule

>>> dv/tb_ascii85_line_wrapped_encoder.sv
// Self-checking testbench for the line-wrapped ASCII85 encoder.
// Depends on a85lw_pkg and ascii85_line_wrapped_encoder; predicts every output character.
`timescale 1ns / 1ps

// Expected-character store plus a transaction-level copy of the encoder state.
class a85_char_predictor;
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } a85_char_t;

  localparam logic [7:0] CH_OFFSET = 8'd33;
  localparam logic [7:0] CH_Z      = 8'h7A;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_GT     = 8'h3E;

  a85_char_t   pending_chars[$];
  int unsigned errors;

  logic [7:0]  line_width_reg;
  logic [31:0] group_acc;
  int unsigned group_bytes;
  logic [8:0]  column;

  function new();
    errors         = 0;
    line_width_reg = 8'd72;
    group_acc      = '0;
    group_bytes    = 0;
    column         = '0;
  endfunction

  function void set_width(logic [7:0] v);
    line_width_reg = v;
  endfunction

  function int unsigned pending();
    return pending_chars.size();
  endfunction

  // Leading base-85 digits of value, most significant first.
  function void push_digits(ref a85_char_t burst[$], input logic [31:0] value,
                            input int unsigned ndig);
    logic [31:0] scale[5];
    logic [31:0] rem;
    logic [31:0] d;
    scale[0] = 32'd52200625;
    scale[1] = 32'd614125;
    scale[2] = 32'd7225;
    scale[3] = 32'd85;
    scale[4] = 32'd1;
    rem = value;
    for (int i = 0; i < ndig; i++) begin
      d   = rem / scale[i];
      rem = rem - d * scale[i];
      burst.push_back('{ch: d[7:0] + CH_OFFSET, last: 1'b0});
    end
  endfunction

  // Newline once the column reaches the even-rounded width.
  function void wrap_line(ref a85_char_t burst[$]);
    logic [7:0] width;
    width = line_width_reg & 8'hFE;
    if (column >= {1'b0, width}) begin
      burst.push_back('{ch: CH_NL, last: 1'b0});
      column = '0;
    end
  endfunction

  // One accepted input transaction: update state, queue the characters it causes.
  function void absorb_input(logic kind, logic [7:0] b);
    a85_char_t burst[$];
    if (kind == a85lw_pkg::KIND_DATA) begin
      group_acc   = {group_acc[23:0], b};
      group_bytes = group_bytes + 1;
      if (group_bytes == 4) begin
        if (group_acc == 32'd0) begin
          burst.push_back('{ch: CH_Z, last: 1'b0});
          column = column + 9'd1;
        end else begin
          push_digits(burst, group_acc, 5);
          column = column + 9'd5;
        end
        wrap_line(burst);
        group_acc   = '0;
        group_bytes = 0;
      end
    end else begin
      // partial group: zero padded, n+1 digits, never 'z'
      if (group_bytes != 0) begin
        push_digits(burst, group_acc << (8 * (4 - group_bytes)), group_bytes + 1);
        column = column + 9'(group_bytes + 1);
        wrap_line(burst);
      end
      burst.push_back('{ch: CH_TILDE, last: 1'b0});
      burst.push_back('{ch: CH_GT, last: 1'b0});
      burst.push_back('{ch: CH_NL, last: 1'b0});
      group_acc   = '0;
      group_bytes = 0;
      column      = '0;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) pending_chars.push_back(burst[i]);
  endfunction

  task flag_mismatch(string what);
    $display("MISMATCH %s", what);
    errors++;
  endtask

  // One accepted output transaction against the oldest expected character.
  task check_char(logic [7:0] ch, logic last);
    a85_char_t want;
    if (pending_chars.size() == 0) begin
      flag_mismatch($sformatf("unexpected char 0x%02h last %0b", ch, last));
    end else begin
      want = pending_chars.pop_front();
      if (ch !== want.ch)
        flag_mismatch($sformatf("out_char 0x%02h, want 0x%02h", ch, want.ch));
      if (last !== want.last)
        flag_mismatch($sformatf("last %0b, want %0b (char 0x%02h)", last, want.last, want.ch));
    end
  endtask
endclass

module tb_ascii85_line_wrapped_encoder;
  import a85lw_pkg::*;

  // Slowest legal run is far below this: ~120 items, at most 9 chars each,
  // receiver ready only 45% of cycles, plus drains between phases.
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 24;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;

  int unsigned snd_idle_pct = 0;   // chance the sender holds off before an item
  int unsigned rcv_idle_pct = 0;   // chance out_tready is low in a cycle
  int unsigned cycle_count = 0;

  a85_char_predictor model = new();

  ascii85_line_wrapped_encoder u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ascii85_line_wrapped_encoder regression: fail");
      $finish;
    end
  end

  // Receiver backpressure, re-rolled every cycle.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // Output monitor: every output transaction goes to the predictor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) model.check_char(out_tdata, out_tlast);
  end

  // One input transaction. Called at a clock edge; returns at the edge where
  // the transaction is accepted, so back-to-back calls keep tvalid high.
  task automatic send_item(logic kind, logic [7:0] b);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    model.absorb_input(kind, b);
  endtask

  task automatic send_group(logic [31:0] g);
    for (int i = 3; i >= 0; i--) send_item(KIND_DATA, g[8*i +: 8]);
  endtask

  // Sender goes quiet until every expected char has come out. The wait is a
  // do-while loop on the clock, so tvalid is not re-driven in the same step.
  task automatic drain_outputs();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (model.pending() != 0);
  endtask

  // Register write only with the encoder idle: drained plus settle time, since
  // a trailing byte that did not close a group leaves nothing to wait on.
  task automatic write_line_width(logic [7:0] v);
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    model.set_width(v);
  endtask

  // Mostly data bytes with runs of zero groups and all-ones bytes, plus the
  // occasional flush that lands on any group phase.
  task automatic send_random_stream(int unsigned count, bit pause_midway);
    int unsigned sent;
    int unsigned roll;
    logic [7:0]  b;
    sent = 0;
    while (sent < count) begin
      if (pause_midway && sent >= count / 2 && sent < count / 2 + 4) begin
        drain_outputs();
        pause_midway = 1'b0;
      end
      roll = $urandom_range(0, 15);
      if (roll == 0) begin
        send_item(KIND_END, 8'($urandom));
        sent++;
      end else if (roll == 1) begin
        send_group(32'd0);
        sent += 4;
      end else begin
        roll = $urandom_range(0, 7);
        if (roll < 2) b = 8'h00;
        else if (roll == 2) b = 8'hFF;
        else b = 8'($urandom);
        send_item(KIND_DATA, b);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles little, receiver a lot.
    snd_idle_pct = 13;
    rcv_idle_pct = 55;

    // Directed, reset width 72: zero group as 'z', all-ones group, flush with
    // nothing held, flushes of one to three bytes, zero partial (digits, no 'z').
    send_group(32'h0000_0000);
    send_group(32'hFFFF_FFFF);
    send_item(KIND_END, 8'hA5);
    send_item(KIND_DATA, 8'h01);
    send_item(KIND_END, 8'h00);
    send_item(KIND_DATA, 8'h7F);
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_END, 8'hFF);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_END, 8'h5A);

    // Width zero: a newline after every group.
    write_line_width(8'd1);
    send_group(32'hFF00_FF00);
    send_group(32'h0000_0000);
    send_item(KIND_DATA, 8'hAB);
    send_item(KIND_END, 8'h00);

    // Widest line, with one full pause mid-stream. The stream is left open
    // so the following width change lands with the column well past it.
    write_line_width(8'd255);
    send_random_stream(30, 1'b1);

    snd_idle_pct = 55;
    rcv_idle_pct = 13;
    write_line_width(8'd2);
    send_random_stream(24, 1'b0);
    write_line_width(8'($urandom_range(3, 253)) | 8'h01);
    send_random_stream(20, 1'b0);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_line_width(8'd72);
    send_random_stream(18, 1'b0);
    send_item(KIND_END, 8'h00);

    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.pending() != 0)
      model.flag_mismatch($sformatf("%0d chars never came out", model.pending()));
    if (model.errors == 0) begin
      $display("ascii85_line_wrapped_encoder regression: pass");
    end else begin
      $display("ascii85_line_wrapped_encoder regression: fail");
    end
    $finish;
  end
endmodule
